>>> rtl/core/bb3_pkg.sv
// Shared types, constants and helper functions of the 3x3 box blur.
package bb3_pkg;

    // Register, dimension and datapath widths, queue depth and default frame limits
    localparam int unsigned REG_W         = 11;
    localparam int unsigned DIM_W         = 17;
    localparam int unsigned COL_MAX_W     = 13;
    localparam int unsigned PIX_W         = 24;
    localparam int unsigned SUM_W         = 12;
    localparam int unsigned NUM_W         = 13;
    localparam int unsigned CNT_W         = 4;
    localparam int unsigned RECIP_W       = 20;
    localparam int unsigned RECIP_SHIFT   = 20;
    localparam int unsigned FIFO_DEPTH    = 4;
    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned MAX_HEIGHT_DEF = 1024;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

    // Request kind on the input channel
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Command kinds passed from front to back
    typedef enum logic {
        OP_WRITE,
        OP_EMIT
    } op_t;

    // One queued command
    typedef struct packed {
        op_t                    op;
        logic [1:0]             slot;
        logic [COL_MAX_W-1:0]   col;
        logic [PIX_W-1:0]       pix;
        logic                   up_ok;
        logic                   down_ok;
        logic                   left_ok;
        logic                   right_ok;
        logic                   last_run;
        logic                   last_frame;
    } entry_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_LAST,
        B_DIV,
        B_OUT
    } back_state_t;

    // Line store slot arithmetic, modulo three
    function automatic logic [1:0] slot_next(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [1:0] slot_prev(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    // ceil(2^RECIP_SHIFT / (2*cnt)): exact floor division for numerators below 2^13
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd5:    m = 20'd104858;
            4'd6:    m = 20'd87382;
            4'd7:    m = 20'd74899;
            4'd8:    m = 20'd65536;
            4'd9:    m = 20'd58255;
            default: m = 20'd524288;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/core/bb3_fifo.sv
// Short command queue between the front and the back of the blur.
module bb3_fifo #(
    parameter int unsigned DEPTH = bb3_pkg::FIFO_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bb3_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output bb3_pkg::entry_t pop_data,
    output logic            empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bb3_pkg::entry_t store_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;

    assign full     = (count_reg == (PW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = store_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && !empty) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && !empty)) begin
            count_next = count_reg + 1'b1;
        end else if (!(push && !full) && (pop && !empty)) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold command payloads
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/bb3_front.sv
// Front end: accepts requests, tracks raster position and queues commands.
module bb3_front #(
    parameter int unsigned MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [7:0]                s_in_red,
    input  logic [7:0]                s_in_green,
    input  logic [7:0]                s_in_blue,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [bb3_pkg::REG_W-1:0] cfg_data,
    output logic                      push,
    output bb3_pkg::entry_t           push_data,
    input  logic                      full
);

    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned DW = bb3_pkg::DIM_W;

    logic [bb3_pkg::REG_W-1:0] fw_reg, fh_reg;
    logic [RW-1:0]             in_row_reg, in_row_next;
    logic [CW-1:0]             in_col_reg, in_col_next;
    logic [1:0]                in_slot_reg, in_slot_next;
    logic [CW-1:0]             drain_col_reg, drain_col_next;
    logic                      draining_reg, draining_next;
    logic [1:0]                drain_slot_reg, drain_slot_next;
    bb3_pkg::entry_t           ent_reg [3];
    bb3_pkg::entry_t           ent_next [3];
    logic [1:0]                ent_cnt_reg, ent_cnt_next;
    logic [1:0]                ent_idx_reg;

    logic [DW-1:0] w_eff, h_eff, w_last, h_last;
    logic          accept, cfg_hit, row_end, row_gt0;
    logic          has_a, has_b;
    bb3_pkg::entry_t e_wr, e_a, e_b, e_dr;

    // Clamp the programmed dimensions
    always_comb begin
        if (fw_reg == '0) begin
            w_eff = DW'(1);
        end else if (DW'(fw_reg) > DW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = DW'(fw_reg);
        end
        if (fh_reg == '0) begin
            h_eff = DW'(1);
        end else if (DW'(fh_reg) > DW'(MAX_HEIGHT)) begin
            h_eff = DW'(MAX_HEIGHT);
        end else begin
            h_eff = DW'(fh_reg);
        end
        w_last = w_eff - 1'b1;
        h_last = h_eff - 1'b1;
    end

    assign s_ready   = (ent_idx_reg >= ent_cnt_reg);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid &&
                       (cfg_index == bb3_pkg::CFG_FRAME_WIDTH ||
                        cfg_index == bb3_pkg::CFG_FRAME_HEIGHT);
    assign push      = (ent_idx_reg < ent_cnt_reg);
    assign push_data = ent_reg[ent_idx_reg];

    assign row_end = (DW'(in_col_reg) >= w_last);
    assign row_gt0 = (in_row_reg != '0);
    assign has_a   = row_gt0 && (in_col_reg != '0);
    assign has_b   = row_gt0 && row_end;

    // Classify the request into store and result commands
    always_comb begin
        e_wr            = '0;
        e_wr.op         = bb3_pkg::OP_WRITE;
        e_wr.slot       = in_slot_reg;
        e_wr.col        = bb3_pkg::COL_MAX_W'(in_col_reg);
        e_wr.pix        = {s_in_red, s_in_green, s_in_blue};

        e_a             = '0;
        e_a.op          = bb3_pkg::OP_EMIT;
        e_a.slot        = bb3_pkg::slot_prev(in_slot_reg);
        e_a.col         = bb3_pkg::COL_MAX_W'(in_col_reg - 1'b1);
        e_a.up_ok       = (in_row_reg > RW'(1));
        e_a.down_ok     = 1'b1;
        e_a.left_ok     = (in_col_reg > CW'(1));
        e_a.right_ok    = 1'b1;
        e_a.last_run    = !row_end;

        e_b             = '0;
        e_b.op          = bb3_pkg::OP_EMIT;
        e_b.slot        = bb3_pkg::slot_prev(in_slot_reg);
        e_b.col         = bb3_pkg::COL_MAX_W'(in_col_reg);
        e_b.up_ok       = (in_row_reg > RW'(1));
        e_b.down_ok     = 1'b1;
        e_b.left_ok     = (in_col_reg != '0);
        e_b.right_ok    = 1'b0;
        e_b.last_run    = 1'b1;

        e_dr            = '0;
        e_dr.op         = bb3_pkg::OP_EMIT;
        e_dr.slot       = drain_slot_reg;
        e_dr.col        = bb3_pkg::COL_MAX_W'(drain_col_reg);
        e_dr.up_ok      = (h_eff > DW'(1));
        e_dr.down_ok    = 1'b0;
        e_dr.left_ok    = (drain_col_reg != '0);
        e_dr.right_ok   = (DW'(drain_col_reg) < w_last);
        e_dr.last_run   = 1'b1;
        e_dr.last_frame = (DW'(drain_col_reg) == w_last);
    end

    // Advance raster position and build the command list
    always_comb begin
        in_row_next     = in_row_reg;
        in_col_next     = in_col_reg;
        in_slot_next    = in_slot_reg;
        drain_col_next  = drain_col_reg;
        draining_next   = draining_reg;
        drain_slot_next = drain_slot_reg;
        ent_next[0]     = ent_reg[0];
        ent_next[1]     = ent_reg[1];
        ent_next[2]     = ent_reg[2];
        ent_cnt_next    = ent_cnt_reg;
        if (cfg_hit) begin
            in_row_next    = '0;
            in_col_next    = '0;
            in_slot_next   = '0;
            drain_col_next = '0;
            draining_next  = 1'b0;
        end else if (accept && s_kind == bb3_pkg::KIND_DRAIN) begin
            ent_next[0]  = e_dr;
            ent_cnt_next = draining_reg ? 2'd1 : 2'd0;
            if (draining_reg) begin
                if (DW'(drain_col_reg) == w_last) begin
                    drain_col_next = '0;
                    draining_next  = 1'b0;
                end else begin
                    drain_col_next = drain_col_reg + 1'b1;
                end
            end
        end else if (accept) begin
            ent_next[0]    = e_wr;
            ent_next[1]    = has_a ? e_a : e_b;
            ent_next[2]    = e_b;
            ent_cnt_next   = 2'd1 + {1'b0, has_a} + {1'b0, has_b};
            draining_next  = 1'b0;
            drain_col_next = '0;
            if (row_end) begin
                in_col_next = '0;
                if (DW'(in_row_reg) >= h_last) begin
                    in_row_next     = '0;
                    in_slot_next    = '0;
                    draining_next   = 1'b1;
                    drain_slot_next = in_slot_reg;
                end else begin
                    in_row_next  = in_row_reg + 1'b1;
                    in_slot_next = bb3_pkg::slot_next(in_slot_reg);
                end
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg         <= bb3_pkg::REG_W'(1024);
            fh_reg         <= bb3_pkg::REG_W'(1024);
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            in_slot_reg    <= '0;
            drain_col_reg  <= '0;
            draining_reg   <= 1'b0;
            drain_slot_reg <= '0;
            ent_cnt_reg    <= '0;
            ent_idx_reg    <= '0;
        end else begin
            // Latch configuration registers
            if (cfg_valid && cfg_index == bb3_pkg::CFG_FRAME_WIDTH) begin
                fw_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == bb3_pkg::CFG_FRAME_HEIGHT) begin
                fh_reg <= cfg_data;
            end
            in_row_reg     <= in_row_next;
            in_col_reg     <= in_col_next;
            in_slot_reg    <= in_slot_next;
            drain_col_reg  <= drain_col_next;
            draining_reg   <= draining_next;
            drain_slot_reg <= drain_slot_next;
            ent_cnt_reg    <= ent_cnt_next;
            // Restart the push index on accept, step it on each push
            if (accept) begin
                ent_idx_reg <= '0;
            end else if (push && !full) begin
                ent_idx_reg <= ent_idx_reg + 1'b1;
            end
        end
    end

    // Hold the pending commands
    always_ff @(posedge aclk) begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
        ent_reg[2] <= ent_next[2];
    end

endmodule

>>> rtl/core/bb3_back.sv
// Back end: line stores, window accumulation and rounded division.
module bb3_back #(
    parameter int unsigned MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    output logic            pop,
    input  bb3_pkg::entry_t pop_data,
    input  logic            empty,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_red,
    output logic [7:0]      m_out_green,
    output logic [7:0]      m_out_blue,
    output logic            m_last_of_run,
    output logic            m_last_of_frame
);

    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned SW = bb3_pkg::SUM_W;
    localparam int unsigned NW = bb3_pkg::NUM_W;
    localparam int unsigned MW = bb3_pkg::RECIP_W;
    localparam int unsigned SH = bb3_pkg::RECIP_SHIFT;

    bb3_pkg::back_state_t state_reg, state_next;
    bb3_pkg::entry_t      job_reg;
    logic [1:0]           k_reg;
    logic                 acc_en_reg, acc_cok_reg;
    logic [SW-1:0]        sum_r_reg, sum_g_reg, sum_b_reg;
    logic [7:0]           out_r_reg, out_g_reg, out_b_reg;
    logic                 out_lr_reg, out_lf_reg;
    logic [bb3_pkg::PIX_W-1:0] rd_data [3];

    logic          mem_we, start_job;
    logic [CW-1:0] rd_col;
    logic          col_ok;
    logic [2:0]    slot_ok;
    logic [1:0]    up_slot, dn_slot;
    logic [SW-1:0] add_r, add_g, add_b;
    logic [bb3_pkg::CNT_W-1:0] cnt;
    logic [MW-1:0] mult;
    logic [NW+MW-1:0] prod_r, prod_g, prod_b;

    // Line stores, one per row slot
    for (genvar g = 0; g < 3; g++) begin : g_line
        logic [bb3_pkg::PIX_W-1:0] mem [MAX_WIDTH];
        always_ff @(posedge aclk) begin
            if (mem_we && pop_data.slot == 2'(g)) begin
                mem[pop_data.col[CW-1:0]] <= pop_data.pix;
            end
            rd_data[g] <= mem[rd_col];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bb3_pkg::B_IDLE: begin
                if (!empty && pop_data.op == bb3_pkg::OP_EMIT) begin
                    state_next = bb3_pkg::B_READ;
                end
            end
            bb3_pkg::B_READ: begin
                if (k_reg == 2'd2) begin
                    state_next = bb3_pkg::B_LAST;
                end
            end
            bb3_pkg::B_LAST: state_next = bb3_pkg::B_DIV;
            bb3_pkg::B_DIV:  state_next = bb3_pkg::B_OUT;
            bb3_pkg::B_OUT: begin
                if (m_ready) begin
                    state_next = bb3_pkg::B_IDLE;
                end
            end
            default: state_next = bb3_pkg::B_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        pop       = 1'b0;
        mem_we    = 1'b0;
        start_job = 1'b0;
        m_valid   = 1'b0;
        unique case (state_reg)
            bb3_pkg::B_IDLE: begin
                pop       = !empty;
                mem_we    = !empty && pop_data.op == bb3_pkg::OP_WRITE;
                start_job = !empty && pop_data.op == bb3_pkg::OP_EMIT;
            end
            bb3_pkg::B_OUT: m_valid = 1'b1;
            default: ;
        endcase
    end

    // Read column and its in-image flag
    always_comb begin
        rd_col = job_reg.col[CW-1:0] - 1'b1 + CW'(k_reg);
        unique case (k_reg)
            2'd0:    col_ok = job_reg.left_ok;
            2'd1:    col_ok = 1'b1;
            default: col_ok = job_reg.right_ok;
        endcase
    end

    // Select the rows inside the image
    always_comb begin
        up_slot = bb3_pkg::slot_prev(job_reg.slot);
        dn_slot = bb3_pkg::slot_next(job_reg.slot);
        for (int g = 0; g < 3; g++) begin
            slot_ok[g] = (job_reg.slot == 2'(g)) ||
                         (job_reg.up_ok && up_slot == 2'(g)) ||
                         (job_reg.down_ok && dn_slot == 2'(g));
        end
    end

    // Column sum of the returned row data
    always_comb begin
        add_r = '0;
        add_g = '0;
        add_b = '0;
        for (int g = 0; g < 3; g++) begin
            if (slot_ok[g]) begin
                add_r = add_r + SW'(rd_data[g][23:16]);
                add_g = add_g + SW'(rd_data[g][15:8]);
                add_b = add_b + SW'(rd_data[g][7:0]);
            end
        end
    end

    // Window count and rounded mean
    always_comb begin
        cnt    = bb3_pkg::CNT_W'(2'd1 + {1'b0, job_reg.up_ok} + {1'b0, job_reg.down_ok}) *
                 bb3_pkg::CNT_W'(2'd1 + {1'b0, job_reg.left_ok} + {1'b0, job_reg.right_ok});
        mult   = bb3_pkg::recip(cnt);
        prod_r = ({sum_r_reg, 1'b0} + NW'(cnt)) * mult;
        prod_g = ({sum_g_reg, 1'b0} + NW'(cnt)) * mult;
        prod_b = ({sum_b_reg, 1'b0} + NW'(cnt)) * mult;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bb3_pkg::B_IDLE;
            acc_en_reg <= 1'b0;
            k_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            acc_en_reg <= (state_reg == bb3_pkg::B_READ);
            if (start_job) begin
                k_reg <= '0;
            end else if (state_reg == bb3_pkg::B_READ) begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Accumulate the window and register the result
    always_ff @(posedge aclk) begin
        acc_cok_reg <= col_ok;
        if (start_job) begin
            job_reg   <= pop_data;
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
        end else if (acc_en_reg && acc_cok_reg) begin
            sum_r_reg <= sum_r_reg + add_r;
            sum_g_reg <= sum_g_reg + add_g;
            sum_b_reg <= sum_b_reg + add_b;
        end
        if (state_reg == bb3_pkg::B_DIV) begin
            out_r_reg  <= prod_r[SH+7:SH];
            out_g_reg  <= prod_g[SH+7:SH];
            out_b_reg  <= prod_b[SH+7:SH];
            out_lr_reg <= job_reg.last_run;
            out_lf_reg <= job_reg.last_frame;
        end
    end

    assign m_out_red       = out_r_reg;
    assign m_out_green     = out_g_reg;
    assign m_out_blue      = out_b_reg;
    assign m_last_of_run   = out_lr_reg;
    assign m_last_of_frame = out_lf_reg;

endmodule

>>> rtl/core/box_blur_3x3_edge_aware.sv
// Top level of the edge-aware 3x3 box blur.
// Pixels arrive in raster order and each leaves as the rounded mean of the in-image pixels of
// its 3x3 window, one row and one column late; a drain request emits one pixel of the bottom
// row after a frame ends. The front takes a new request only once it has queued every
// command of the last one (one store and up to two results per pixel). The back pops a store
// into its line store, and takes a result through a pop, three column reads of the line
// stores, a settle, a divide and an output that waits on m_ready. A four-entry queue lets
// front and back stall apart. Line stores need no clearing after reset.
module box_blur_3x3_edge_aware #(
    parameter int unsigned MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [7:0]                s_in_red,
    input  logic [7:0]                s_in_green,
    input  logic [7:0]                s_in_blue,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_red,
    output logic [7:0]                m_out_green,
    output logic [7:0]                m_out_blue,
    output logic                      m_last_of_run,
    output logic                      m_last_of_frame,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [bb3_pkg::REG_W-1:0] cfg_data
);

    logic            push, full, pop, empty;
    bb3_pkg::entry_t push_data, pop_data;

    bb3_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_in_red  (s_in_red),
        .s_in_green(s_in_green),
        .s_in_blue (s_in_blue),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    bb3_fifo #(
        .DEPTH(bb3_pkg::FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty)
    );

    bb3_back #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop            (pop),
        .pop_data       (pop_data),
        .empty          (empty),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_last_of_run  (m_last_of_run),
        .m_last_of_frame(m_last_of_frame)
    );

    // The bottom-right pixel always closes its request
    a_frame_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_frame) |-> m_last_of_run)
        else $error("last_of_frame without last_of_run");

    // The front never takes a new request while commands are still pending
    a_no_accept_while_pushing: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !s_ready)
        else $error("request accepted with commands pending");

    // The back never pops while a result is held
    a_no_pop_while_holding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !pop)
        else $error("queue popped while result held");

endmodule

>>> tb/sv/box_blur_3x3_edge_aware_test.sv
// Self-checking testbench of the edge-aware 3x3 box blur: directed and random streams checked against a predictor.
`timescale 1ns / 100ps

module box_blur_3x3_edge_aware_test;

    localparam int unsigned LINE_LEN   = 1024;
    localparam int unsigned SETTLE_CYC = 120;
    localparam logic [1:0]  CFG_SPARE  = 2'd3;

    typedef struct {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_req_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_run;
        logic       last_frame;
    } blur_px_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_kind = bb3_pkg::KIND_PIXEL;
    logic [7:0] s_in_red = '0, s_in_green = '0, s_in_blue = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_out_red, m_out_green, m_out_blue;
    logic m_last_of_run, m_last_of_frame;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = bb3_pkg::CFG_FRAME_WIDTH;
    logic [bb3_pkg::REG_W-1:0] cfg_data = '0;

    box_blur_3x3_edge_aware dut (.*);

    // Clock: 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pixel_req_t pend_q[$];
    blur_px_t   blur_q[$];
    int unsigned send_idle = 0, recv_stall = 0, hold_cnt = 0;
    int unsigned fail_cnt = 0, req_cnt = 0, px_cnt = 0, cfg_cnt = 0;
    bit s_taken = 1'b0;

    // Predictor state
    logic [23:0] line_mem [3][LINE_LEN];
    int unsigned cur_w = 1024, cur_h = 1024;
    int unsigned row_pos = 0, col_pos = 0, flush_col = 0;
    bit flushing = 1'b0;

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v < 1) return 1;
        if (v > LINE_LEN) return LINE_LEN;
        return v;
    endfunction

    // Average the in-image neighbors of (cr,cc) and queue the expected pixel
    task automatic blur_at(int cr, int cc, bit last_run);
        int sr, sg, sb, cnt, r, c;
        logic [23:0] p;
        blur_px_t e;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (r = cr - 1; r <= cr + 1; r++) begin
            for (c = cc - 1; c <= cc + 1; c++) begin
                if (r >= 0 && r < int'(cur_h) && c >= 0 && c < int'(cur_w)) begin
                    p = line_mem[r % 3][c];
                    sr += p[23:16]; sg += p[15:8]; sb += p[7:0];
                    cnt++;
                end
            end
        end
        if (cnt == 0) cnt = 1;
        e.red = 8'((2 * sr + cnt) / (2 * cnt));
        e.green = 8'((2 * sg + cnt) / (2 * cnt));
        e.blue = 8'((2 * sb + cnt) / (2 * cnt));
        e.last_run = last_run;
        e.last_frame = (cr == int'(cur_h) - 1) && (cc == int'(cur_w) - 1);
        blur_q.push_back(e);
    endtask

    // Advance the predictor by one accepted request
    task automatic predict_req(pixel_req_t it);
        bit row_end;
        if (it.kind == bb3_pkg::KIND_DRAIN) begin
            if (flushing) begin
                blur_at(cur_h - 1, flush_col, 1'b1);
                flush_col++;
                if (flush_col >= cur_w) begin
                    flush_col = 0;
                    flushing = 1'b0;
                end
            end
        end else begin
            flushing = 1'b0;
            flush_col = 0;
            row_end = (col_pos >= cur_w - 1);
            line_mem[row_pos % 3][col_pos] = {it.red, it.green, it.blue};
            if (row_pos >= 1) begin
                if (col_pos >= 1) blur_at(row_pos - 1, col_pos - 1, !row_end);
                if (row_end) blur_at(row_pos - 1, col_pos, 1'b1);
            end
            if (row_end) begin
                col_pos = 0;
                if (row_pos >= cur_h - 1) begin
                    row_pos = 0;
                    flushing = 1'b1;
                end else begin
                    row_pos++;
                end
            end else begin
                col_pos++;
            end
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, px_cnt);
        fail_cnt++;
    endtask

    // Monitor: follow requests, register writes and results at the rising edge
    always @(posedge aclk) begin
        pixel_req_t it;
        blur_px_t e;
        s_taken = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == bb3_pkg::CFG_FRAME_WIDTH ||
                    cfg_index == bb3_pkg::CFG_FRAME_HEIGHT) begin
                    if (cfg_index == bb3_pkg::CFG_FRAME_WIDTH) cur_w = clamp_dim(cfg_data);
                    else cur_h = clamp_dim(cfg_data);
                    row_pos = 0; col_pos = 0; flush_col = 0; flushing = 1'b0;
                end
                cfg_cnt++;
            end
            if (s_valid && s_ready) begin
                it.kind = s_kind; it.red = s_in_red;
                it.green = s_in_green; it.blue = s_in_blue;
                predict_req(it);
                req_cnt++;
                s_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                px_cnt++;
                if (blur_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    e = blur_q.pop_front();
                    if (m_out_red !== e.red) report_mismatch("red", m_out_red, e.red);
                    if (m_out_green !== e.green) report_mismatch("green", m_out_green, e.green);
                    if (m_out_blue !== e.blue) report_mismatch("blue", m_out_blue, e.blue);
                    if (m_last_of_run !== e.last_run)
                        report_mismatch("last_of_run", m_last_of_run, e.last_run);
                    if (m_last_of_frame !== e.last_frame)
                        report_mismatch("last_of_frame", m_last_of_frame, e.last_frame);
                end
            end
        end
    end

    // Driver: offer the next pending request, with random gaps
    always @(negedge aclk) begin
        pixel_req_t it;
        if (aresetn && (!s_valid || s_taken)) begin
            if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                it = pend_q.pop_front();
                s_valid <= 1'b1;
                s_kind <= it.kind;
                s_in_red <= it.red;
                s_in_green <= it.green;
                s_in_blue <= it.blue;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic push_req(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_req_t it;
        it.kind = kind; it.red = r; it.green = g; it.blue = b;
        pend_q.push_back(it);
    endtask

    task automatic push_rand_px();
        push_req(bb3_pkg::KIND_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic push_rand_drain();
        push_req(bb3_pkg::KIND_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // One frame of random pixels with stray drains, then a full, long or cut-short drain
    task automatic push_frame(int unsigned w, int unsigned h);
        int unsigned n, k;
        for (n = 0; n < w * h; n++) begin
            if ($urandom_range(99) < 6) push_rand_drain();
            push_rand_px();
        end
        k = $urandom_range(99);
        n = (k < 15) ? $urandom_range(w - 1) : (k < 30) ? w + 2 : w;
        repeat (n) push_rand_drain();
    endtask

    // Wait until the block has drained all work, then settle
    task automatic wait_idle();
        while (pend_q.size() > 0 || s_valid || blur_q.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [bb3_pkg::REG_W-1:0] val);
        int unsigned seen;
        @(negedge aclk);
        seen = cfg_cnt;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge aclk); while (cfg_cnt == seen);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(int unsigned mode);
        case (mode % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 52; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 52; end
            default: begin send_idle = 23; recv_stall = 23; end
        endcase
    endtask

    task automatic run_phase(int unsigned mode, logic [bb3_pkg::REG_W-1:0] w,
                             logic [bb3_pkg::REG_W-1:0] h, int unsigned frames);
        write_reg(bb3_pkg::CFG_FRAME_WIDTH, w);
        write_reg(bb3_pkg::CFG_FRAME_HEIGHT, h);
        set_idling(mode);
        repeat (frames) push_frame(clamp_dim(w), clamp_dim(h));
        wait_idle();
    endtask

    initial begin
        int unsigned n;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: default size, row zero only, drains with nothing pending
        push_req(bb3_pkg::KIND_DRAIN, 8'hff, 8'hff, 8'hff);
        push_req(bb3_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00);
        push_req(bb3_pkg::KIND_PIXEL, 8'hff, 8'hff, 8'hff);
        push_req(bb3_pkg::KIND_DRAIN, 8'h00, 8'h00, 8'h00);
        wait_idle();

        // Directed: 3x3 frame of extremes, full drain, one spare tick
        write_reg(bb3_pkg::CFG_FRAME_WIDTH, 11'd3);
        write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 11'd3);
        for (n = 0; n < 9; n++) begin
            if (n % 2 == 0) push_req(bb3_pkg::KIND_PIXEL, 8'hff, 8'h00, 8'hff);
            else push_req(bb3_pkg::KIND_PIXEL, 8'h00, 8'hff, 8'h00);
        end
        repeat (4) push_req(bb3_pkg::KIND_DRAIN, 8'h00, 8'h00, 8'h00);
        // Pixel abandons a partial drain
        repeat (9) push_req(bb3_pkg::KIND_PIXEL, 8'hff, 8'hff, 8'hff);
        push_req(bb3_pkg::KIND_DRAIN, 8'h00, 8'h00, 8'h00);
        push_req(bb3_pkg::KIND_PIXEL, 8'h80, 8'h7f, 8'h01);
        wait_idle();
        write_reg(CFG_SPARE, 11'h7ff);

        // Random phases over sizes and idling modes
        run_phase(0, 11'd1, 11'd1, 20);
        run_phase(1, 11'd1, 11'd5, 10);
        run_phase(2, 11'd5, 11'd1, 10);
        run_phase(3, 11'd4, 11'd3, 10);

        // Long receiver hold-off while requests keep coming
        write_reg(bb3_pkg::CFG_FRAME_WIDTH, 11'd8);
        write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 11'd6);
        set_idling(0);
        hold_cnt = 400;
        repeat (5) push_frame(8, 6);
        wait_idle();

        // Clamped extremes, partial frames only
        write_reg(bb3_pkg::CFG_FRAME_WIDTH, 11'd0);
        write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 11'h7ff);
        set_idling(3);
        repeat (40) push_rand_px();
        wait_idle();
        write_reg(bb3_pkg::CFG_FRAME_WIDTH, 11'h7ff);
        write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 11'd2);
        set_idling(1);
        repeat (40) push_rand_px();
        repeat (3) push_rand_drain();
        wait_idle();

        run_phase(2, 11'd16, 11'd4, 4);
        run_phase(3, 11'd2, 11'd2, 20);
        run_phase(0, 11'd1024, 11'd1, 0);

        $display("Covered %0d requests, %0d blurred pixels, %0d register writes.",
                 req_cnt, px_cnt, cfg_cnt);
        $display("Sizes 1x1 up to clamped 1024 wide, drains full, cut short and spare.");
        if (fail_cnt == 0) begin
            $display("box_blur_3x3_edge_aware test passed");
        end else begin
            $display("box_blur_3x3_edge_aware test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("box_blur_3x3_edge_aware test failed");
        $finish;
    end

endmodule
